### src/tgd_pkg.sv
// tgd_pkg: shared types and constants of the touch gesture detector
// item kinds, event codes, register indexes, reset values, config struct
// no dependencies
`default_nettype none

package tgd_pkg;

	localparam int KIND_W     = 2;
	localparam int EV_W       = 2;
	localparam int SAMPLE_W   = 16;
	localparam int TIME_W     = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_W     = 9;

	localparam logic [KIND_W-1:0] KIND_START = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CAL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_GEST  = 2'd2;

	localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
	localparam logic [EV_W-1:0] EV_TAP    = 2'd1;
	localparam logic [EV_W-1:0] EV_DOUBLE = 2'd2;
	localparam logic [EV_W-1:0] EV_HOLD   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DROP     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DTAP     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TAP  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_G_SLOW   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_G_FAST   = 4'd7;

	localparam logic [15:0] RST_DROP     = 16'd35;
	localparam logic [15:0] RST_HOLD     = 16'd2000;
	localparam logic [15:0] RST_DTAP     = 16'd500;
	localparam logic [15:0] RST_MIN_TAP  = 16'd20;
	localparam logic [15:0] RST_INTERVAL = 16'd200;
	localparam logic [15:0] RST_WARMUP   = 16'd5000;
	localparam logic [GAIN_W-1:0] RST_G_SLOW = 9'd38;
	localparam logic [GAIN_W-1:0] RST_G_FAST = 9'd128;
	localparam logic [GAIN_W-1:0] GAIN_ONE   = 9'd256;

	typedef struct packed {
		logic [15:0]       drop_threshold;
		logic [15:0]       hold_time_ms;
		logic [15:0]       dtap_window_ms;
		logic [15:0]       min_tap_ms;
		logic [15:0]       baseline_interval_ms;
		logic [15:0]       warmup_ms;
		logic [GAIN_W-1:0] gain_slow;
		logic [GAIN_W-1:0] gain_fast;
	} cfg_t;

	// gesture sample seen while enabled, and its touch decision
	typedef struct packed {
		logic active;
		logic touched;
	} judge_t;

endpackage

`default_nettype wire

### src/tgd_in_if.sv
// tgd_in_if: input channel of the touch gesture detector
// valid/ready handshake with kind, sample and timestamp; uses tgd_pkg
`default_nettype none

interface tgd_in_if;
	logic                          valid;
	logic                          ready;
	logic [tgd_pkg::KIND_W-1:0]    kind;
	logic [tgd_pkg::SAMPLE_W-1:0]  sample;
	logic [tgd_pkg::TIME_W-1:0]    now_ms;

	modport source (output valid, kind, sample, now_ms, input ready);
	modport sink (input valid, kind, sample, now_ms, output ready);
endinterface

`default_nettype wire

### src/tgd_out_if.sv
// tgd_out_if: result channel of the touch gesture detector
// valid/ready handshake with event, touched flag and baseline; uses tgd_pkg
`default_nettype none

interface tgd_out_if;
	logic                          valid;
	logic                          ready;
	logic [tgd_pkg::EV_W-1:0]      event_res;
	logic                          touched;
	logic [tgd_pkg::SAMPLE_W-1:0]  baseline_level;

	modport source (output valid, event_res, touched, baseline_level, input ready);
	modport sink (input valid, event_res, touched, baseline_level, output ready);
endinterface

`default_nettype wire

### src/tgd_cfg_regs.sv
// tgd_cfg_regs: configuration registers written through a plain write port
// uses tgd_pkg for indexes, reset values and the config struct
`default_nettype none

module tgd_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             we,
	input  wire logic [tgd_pkg::CFG_IDX_W-1:0]    idx,
	input  wire logic [tgd_pkg::CFG_DATA_W-1:0]   data,
	output tgd_pkg::cfg_t                         cfg
);

	tgd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drop_threshold       <= tgd_pkg::RST_DROP;
			cfg_q.hold_time_ms         <= tgd_pkg::RST_HOLD;
			cfg_q.dtap_window_ms       <= tgd_pkg::RST_DTAP;
			cfg_q.min_tap_ms           <= tgd_pkg::RST_MIN_TAP;
			cfg_q.baseline_interval_ms <= tgd_pkg::RST_INTERVAL;
			cfg_q.warmup_ms            <= tgd_pkg::RST_WARMUP;
			cfg_q.gain_slow            <= tgd_pkg::RST_G_SLOW;
			cfg_q.gain_fast            <= tgd_pkg::RST_G_FAST;
		end else if (we) begin
			unique case (idx)
				tgd_pkg::REG_DROP:     cfg_q.drop_threshold       <= data;
				tgd_pkg::REG_HOLD:     cfg_q.hold_time_ms         <= data;
				tgd_pkg::REG_DTAP:     cfg_q.dtap_window_ms       <= data;
				tgd_pkg::REG_MIN_TAP:  cfg_q.min_tap_ms           <= data;
				tgd_pkg::REG_INTERVAL: cfg_q.baseline_interval_ms <= data;
				tgd_pkg::REG_WARMUP:   cfg_q.warmup_ms            <= data;
				tgd_pkg::REG_G_SLOW:   cfg_q.gain_slow <= data[tgd_pkg::GAIN_W-1:0];
				tgd_pkg::REG_G_FAST:   cfg_q.gain_fast <= data[tgd_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### src/tgd_baseline.sv
// tgd_baseline: adaptive baseline, calibration maximum and touch decision
// uses tgd_pkg; state advances once per item on adv
`default_nettype none

module tgd_baseline #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            adv,
	input  wire logic [tgd_pkg::KIND_W-1:0]      kind,
	input  wire logic [tgd_pkg::SAMPLE_W-1:0]    sample,
	input  wire logic [tgd_pkg::TIME_W-1:0]      now_ms,
	input  wire tgd_pkg::cfg_t                   cfg,
	output tgd_pkg::judge_t                      judge,
	output logic [tgd_pkg::SAMPLE_W-1:0]         level_next
);

	localparam int W  = tgd_pkg::SAMPLE_W + FRAC_BITS;
	localparam int AW = W + 11;

	logic [W-1:0]                     level_q;
	logic [tgd_pkg::SAMPLE_W-1:0]     calmax_q;
	logic [tgd_pkg::TIME_W-1:0]       last_q;
	logic [tgd_pkg::TIME_W-1:0]       start_q;
	logic                             enabled_q;

	logic [W-1:0]                     samp_fx;
	logic [W-1:0]                     lvl0;
	logic [tgd_pkg::SAMPLE_W-1:0]     lint;
	logic                             touched_raw;
	logic                             upd;
	logic                             warm;
	logic [tgd_pkg::GAIN_W-1:0]       g_raw;
	logic [tgd_pkg::GAIN_W-1:0]       g;
	logic signed [W:0]                diff;
	logic signed [AW-1:0]             prod;
	logic signed [AW-1:0]             acc;
	logic [W-1:0]                     lvl_upd;
	logic [tgd_pkg::SAMPLE_W-1:0]     calmax_n;
	logic [W-1:0]                     level_n;
	logic                             gest;

	assign samp_fx     = {sample, {FRAC_BITS{1'b0}}};
	assign lvl0        = (level_q == '0) ? samp_fx : level_q;
	assign lint        = lvl0[W-1:FRAC_BITS];
	assign touched_raw = {1'b0, lint} >= ({1'b0, sample} + {1'b0, cfg.drop_threshold});
	assign upd   = !touched_raw && ((now_ms - last_q) >= {16'd0, cfg.baseline_interval_ms});
	assign warm  = (now_ms - start_q) < {16'd0, cfg.warmup_ms};
	assign g_raw = warm ? cfg.gain_fast : cfg.gain_slow;
	assign g     = (g_raw > tgd_pkg::GAIN_ONE) ? tgd_pkg::GAIN_ONE : g_raw;

	// new = level + g * (sample - level) / 256, rounded half up
	assign diff    = $signed({1'b0, samp_fx}) - $signed({1'b0, lvl0});
	assign prod    = $signed({1'b0, g}) * diff;
	assign acc     = $signed({3'b000, lvl0, 8'd0}) + prod + AW'(128);
	assign lvl_upd = acc[W+7:8];

	assign calmax_n = (sample > calmax_q) ? sample : calmax_q;
	assign gest     = (kind == tgd_pkg::KIND_GEST) && enabled_q;

	always_comb begin
		level_n = level_q;
		unique case (kind)
			tgd_pkg::KIND_START: level_n = level_q;
			tgd_pkg::KIND_CAL:   level_n = {calmax_n, {FRAC_BITS{1'b0}}};
			tgd_pkg::KIND_GEST:  level_n = enabled_q ? (upd ? lvl_upd : lvl0) : level_q;
			default:             level_n = level_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			calmax_q  <= '0;
			last_q    <= '0;
			start_q   <= '0;
			enabled_q <= 1'b0;
		end else if (adv) begin
			level_q <= level_n;
			unique case (kind)
				tgd_pkg::KIND_START: begin
					enabled_q <= 1'b1;
					start_q   <= now_ms;
					calmax_q  <= '0;
				end
				tgd_pkg::KIND_CAL: calmax_q <= calmax_n;
				tgd_pkg::KIND_GEST: begin
					if (enabled_q && upd)
						last_q <= now_ms;
				end
				default: ;
			endcase
		end
	end

	assign judge      = {gest, gest && touched_raw};
	assign level_next = level_n[W-1:FRAC_BITS];

endmodule

`default_nettype wire

### src/tgd_gesture_fsm.sv
// tgd_gesture_fsm: idle / touching / wait / hold machine giving tap, double-tap and hold events
// uses tgd_pkg; takes the touch decision from tgd_baseline
`default_nettype none

module tgd_gesture_fsm (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           adv,
	input  wire logic [tgd_pkg::KIND_W-1:0]     kind,
	input  wire logic [tgd_pkg::TIME_W-1:0]     now_ms,
	input  wire tgd_pkg::judge_t                judge,
	input  wire tgd_pkg::cfg_t                  cfg,
	output logic [tgd_pkg::EV_W-1:0]            ev
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_TOUCH = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_HOLD  = 2'd3;

	logic [1:0]                    state_q, state_n;
	logic                          late_q, late_n;
	logic [tgd_pkg::TIME_W-1:0]    press_q, lift_q;
	logic                          set_press, set_lift;
	logic [tgd_pkg::TIME_W-1:0]    dur_press, dur_lift;
	logic                          held;

	assign dur_press = now_ms - press_q;
	assign dur_lift  = now_ms - lift_q;
	assign held      = dur_press >= {16'd0, cfg.hold_time_ms};

	always_comb begin
		state_n   = state_q;
		late_n    = late_q;
		set_press = 1'b0;
		set_lift  = 1'b0;
		ev        = tgd_pkg::EV_NONE;
		if (kind == tgd_pkg::KIND_START) begin
			state_n = ST_IDLE;
			late_n  = 1'b0;
		end else if (judge.active) begin
			unique case (state_q)
				ST_IDLE: begin
					if (judge.touched) begin
						state_n   = ST_TOUCH;
						set_press = 1'b1;
						late_n    = 1'b0;
					end
				end
				ST_TOUCH: begin
					if (!judge.touched) begin
						priority if (held || late_q)
							state_n = ST_IDLE;
						else if (dur_press >= {16'd0, cfg.min_tap_ms}) begin
							state_n  = ST_WAIT;
							set_lift = 1'b1;
						end else
							state_n = ST_IDLE;
					end else if (held) begin
						ev      = tgd_pkg::EV_HOLD;
						state_n = ST_HOLD;
					end
				end
				ST_WAIT: begin
					if (judge.touched) begin
						if (dur_lift <= {16'd0, cfg.dtap_window_ms}) begin
							ev     = tgd_pkg::EV_DOUBLE;
							late_n = 1'b0;
						end else begin
							late_n = 1'b1;
						end
						state_n   = ST_TOUCH;
						set_press = 1'b1;
					end else if (dur_lift > {16'd0, cfg.dtap_window_ms}) begin
						ev      = tgd_pkg::EV_TAP;
						state_n = ST_IDLE;
					end
				end
				ST_HOLD: begin
					if (!judge.touched)
						state_n = ST_IDLE;
				end
				default: state_n = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			late_q  <= 1'b0;
			press_q <= '0;
			lift_q  <= '0;
		end else if (adv) begin
			state_q <= state_n;
			late_q  <= late_n;
			if (set_press)
				press_q <= now_ms;
			if (set_lift)
				lift_q <= now_ms;
		end
	end

endmodule

`default_nettype wire

### src/touch_gesture_detector.sv
// touch_gesture_detector: top level, input register, result register, submodules
// uses tgd_pkg, tgd_in_if, tgd_out_if, tgd_cfg_regs, tgd_baseline, tgd_gesture_fsm
//
// channel   dir  handshake      payload
// samples   in   valid/ready    kind, sample, now_ms
// results   out  valid/ready    event_res, touched, baseline_level
// cfg       in   cfg_we         cfg_idx, cfg_data
//
// one item per cycle unless results stall; items pass input, then result register
// the state update of one item completes as it moves from input register
// to result register, so the next item sees it at once
// a stalled result holds the input register; samples.ready drops only when both are full
// arst_n clears all state to idle, zero baseline, disabled, register reset values
`default_nettype none

module touch_gesture_detector #(
	parameter int BASELINE_FRAC_BITS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	tgd_in_if.sink                                samples,
	tgd_out_if.source                             results,
	input  wire logic                             cfg_we,
	input  wire logic [tgd_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [tgd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	tgd_pkg::cfg_t                     cfg;
	tgd_pkg::judge_t                   judge;

	logic                              valid_s1;
	logic [tgd_pkg::KIND_W-1:0]        kind_s1;
	logic [tgd_pkg::SAMPLE_W-1:0]      sample_s1;
	logic [tgd_pkg::TIME_W-1:0]        now_s1;

	logic                              res_valid_q;
	logic [tgd_pkg::EV_W-1:0]          ev_q;
	logic                              touched_q;
	logic [tgd_pkg::SAMPLE_W-1:0]      level_q;

	logic                              adv;
	logic                              take;
	logic [tgd_pkg::EV_W-1:0]          ev;
	logic [tgd_pkg::SAMPLE_W-1:0]      level_next;

	assign adv           = valid_s1 && (!res_valid_q || results.ready);
	assign samples.ready = !valid_s1 || adv;
	assign take          = samples.valid && samples.ready;

	tgd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tgd_baseline #(
		.FRAC_BITS (BASELINE_FRAC_BITS)
	) u_base (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.kind       (kind_s1),
		.sample     (sample_s1),
		.now_ms     (now_s1),
		.cfg        (cfg),
		.judge      (judge),
		.level_next (level_next)
	);

	tgd_gesture_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.kind   (kind_s1),
		.now_ms (now_s1),
		.judge  (judge),
		.cfg    (cfg),
		.ev     (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_s1   <= samples.kind;
			sample_s1 <= samples.sample;
			now_s1    <= samples.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_q      <= ev;
			touched_q <= judge.touched;
			level_q   <= level_next;
		end
	end

	assign results.valid          = res_valid_q;
	assign results.event_res      = ev_q;
	assign results.touched        = touched_q;
	assign results.baseline_level = level_q;

	a_full_stall : assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid_q && !results.ready) |-> !samples.ready)
		else $error("input taken while both stages are full and stalled");

	a_adv_result : assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid_q)
		else $error("processed item left no result");

	a_start_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1 == tgd_pkg::KIND_START) |=>
		(ev_q == tgd_pkg::EV_NONE && !touched_q))
		else $error("start item produced an event or touch");

	a_idle_quiet : assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !judge.active) |-> (ev == tgd_pkg::EV_NONE && !judge.touched))
		else $error("non-gesture item produced an event or touch");

endmodule

`default_nettype wire
